/* rtl/rcxh_pkg.sv */
// ----------------------------------------------------------------------------
// rcxh_pkg
// Shared types and constants for the ray / convex hexahedron hit block.
// ----------------------------------------------------------------------------
package rcxh_pkg;

    localparam int NUM_PLANES = 6;
    localparam int PIDX_W     = $clog2(NUM_PLANES);
    localparam int ACC_W      = 52;   // plane value / dot accumulator, signed
    localparam int T_W        = 31;   // ray parameter, unsigned Q15.16
    localparam int FRAC_W     = 16;
    localparam int MUL_W      = 33;   // shared multiplier operand width
    localparam int PROD_W     = 2 * MUL_W;
    localparam int SUM_W      = 64;   // sum of squares
    localparam int RAD_W      = 62;   // sqrt radicand

    localparam logic [T_W-1:0] SAT31     = {T_W{1'b1}};
    localparam logic [15:0]    TOL_RESET = 16'd66;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic               op;
        logic [2:0]         plane_slot;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic signed [31:0] plane_offset;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } in_item_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] hit_x;
        logic signed [31:0] hit_y;
        logic signed [31:0] hit_z;
        logic [T_W-1:0]     ray_param;
        logic [T_W-1:0]     distance;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
        logic signed [31:0] off;
    } plane_t;

endpackage

/* rtl/rcxh_div.sv */
// ----------------------------------------------------------------------------
// rcxh_div
// Restoring divider: q = num * 2^16 / den, one quotient bit per cycle,
// saturated to 31 bits.
// ----------------------------------------------------------------------------
module rcxh_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [rcxh_pkg::ACC_W-1:0]    num,
    input  logic [rcxh_pkg::ACC_W-1:0]    den,
    output logic                          done,
    output logic [rcxh_pkg::T_W-1:0]      quot
);

    localparam int W  = rcxh_pkg::ACC_W;
    localparam int TW = rcxh_pkg::T_W;
    localparam int FW = rcxh_pkg::FRAC_W;
    localparam int SW = W + TW - FW;   // room for den << (TW-FW)

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  den_reg, den_next;
    logic [TW-1:0] bits_reg, bits_next;
    logic [TW-1:0] quot_reg, quot_next;

    logic [SW-1:0] den_sh;
    logic [W:0]    rem_sh;
    logic          sat;

    always_comb begin
        den_sh    = SW'(den) << (TW - FW);
        sat       = SW'(num) >= den_sh;
        rem_sh    = {rem_reg, bits_reg[TW-1]};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        bits_next = bits_reg;
        quot_next = quot_reg;
        if (start) begin
            den_next  = den;
            cnt_next  = 5'(TW - 1);
            rem_next  = num >> (TW - FW);
            bits_next = {num[TW-FW-1:0], {FW{1'b0}}};
            quot_next = '0;
            if (sat) begin
                quot_next = rcxh_pkg::SAT31;
                done_next = 1'b1;
            end else begin
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            bits_next = bits_reg << 1;
            if (rem_sh >= {1'b0, den_reg}) begin
                rem_next  = W'(rem_sh - {1'b0, den_reg});
                quot_next = {quot_reg[TW-2:0], 1'b1};
            end else begin
                rem_next  = W'(rem_sh);
                quot_next = {quot_reg[TW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        bits_reg <= bits_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

/* rtl/rcxh_sqrt.sv */
// ----------------------------------------------------------------------------
// rcxh_sqrt
// Integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module rcxh_sqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [rcxh_pkg::RAD_W-1:0]    radicand,
    output logic                          done,
    output logic [rcxh_pkg::T_W-1:0]      root
);

    localparam int RW = rcxh_pkg::RAD_W;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [RW-1:0] val_reg, val_next;
    logic [RW-1:0] res_reg, res_next;
    logic [RW-1:0] bit_reg, bit_next;
    logic [RW:0]   trial;

    always_comb begin
        trial     = {1'b0, res_reg} + {1'b0, bit_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        val_next  = val_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        if (start) begin
            busy_next = 1'b1;
            val_next  = radicand;
            res_next  = '0;
            bit_next  = RW'(1) << (RW - 2);
        end else if (busy_reg) begin
            if ({1'b0, val_reg} >= trial) begin
                val_next = RW'({1'b0, val_reg} - trial);
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0]) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        val_reg <= val_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[rcxh_pkg::T_W-1:0];

endmodule

/* rtl/ray_convex_hexahedron_hit.sv */
// ----------------------------------------------------------------------------
// ray_convex_hexahedron_hit
// Ray against a convex volume bounded by a table of planes, Q16.16.
// ----------------------------------------------------------------------------
// A load item (op 0) writes one plane into the table. A query
// item (op 1) runs a sequencer around one shared 33x33 multiplier, an
// iterative divider and an iterative square root, and gives one result item.
// Per plane: 6 multiply steps, then a divide if the plane faces the ray,
// then 3 hit-point and up to 3*NUM_PLANES inside-test multiplies unless
// the candidate cannot beat the best t so far. A hit adds 3 multiplies for
// the squared distance and, unless it overflows, the root. s_ready is low
// throughout a query. A finished result waits in the output register;
// loads are still taken meanwhile. The tolerance register is written
// through cfg_* at any idle time.
module ray_convex_hexahedron_hit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  rcxh_pkg::in_item_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rcxh_pkg::out_item_t   m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [15:0]           cfg_data
);

    localparam int NP  = rcxh_pkg::NUM_PLANES;
    localparam int PW  = rcxh_pkg::PIDX_W;
    localparam int AW  = rcxh_pkg::ACC_W;
    localparam int TW  = rcxh_pkg::T_W;
    localparam int MW  = rcxh_pkg::MUL_W;
    localparam int PRW = rcxh_pkg::PROD_W;
    localparam int SMW = rcxh_pkg::SUM_W;
    localparam int RW  = rcxh_pkg::RAD_W;

    localparam logic signed [AW-1:0] MAX32 = AW'(64'sh7FFF_FFFF);
    localparam logic signed [AW-1:0] MIN32 = -AW'(64'sh8000_0000);
    localparam logic [SMW-1:0]       FAR_LIMIT = SMW'(1) << RW;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_ACC, ST_DIV, ST_SQRT, ST_OUT
    } state_t;

    // what the multiply / accumulate loop is working on
    typedef enum logic [2:0] {
        J_VAL, J_DOT, J_PT, J_IN, J_DST
    } job_t;

    state_t state_reg, state_next;
    job_t   job_reg, job_next;

    logic [1:0]                k_reg, k_next;
    logic [PW-1:0]             pi_reg, pi_next;
    logic [PW-1:0]             j_reg, j_next;
    logic signed [AW-1:0]      acc_reg, acc_next;
    logic signed [AW-1:0]      val_reg, val_next;
    logic [TW-1:0]             t_reg, t_next;
    logic [TW-1:0]             best_t_reg, best_t_next;
    logic                      found_reg, found_next;
    logic [SMW-1:0]            sum_reg, sum_next;
    logic                      far_reg, far_next;
    logic [TW-1:0]             dist_reg, dist_next;
    logic signed [PRW-1:0]     prod_reg, prod_next;
    logic signed [31:0]        o_reg [3];
    logic signed [31:0]        d_reg [3];
    logic signed [31:0]        p_reg [3], p_next [3];
    logic signed [31:0]        bp_reg [3], bp_next [3];
    logic [15:0]               tol_reg;
    logic                      m_valid_reg, m_valid_next;
    rcxh_pkg::out_item_t       m_data_reg, m_data_next;
    rcxh_pkg::plane_t          table_reg [NP];

    // datapath
    logic [PW-1:0]             tidx;
    rcxh_pkg::plane_t          ent;
    logic signed [31:0]        nk, ok, dk, pk, bpk;
    logic signed [AW-1:0]      fprod, base, acc_sum, pt_sum;
    logic signed [31:0]        pt_sat;
    logic signed [32:0]        df, dm;
    logic                      far_k;
    logic signed [MW-1:0]      mul_a, mul_b;
    logic                      adv;

    logic                      s_fire, load_we, div_start, div_done, sqrt_start, sqrt_done;
    logic [AW-1:0]             div_num, div_den;
    logic [TW-1:0]             div_q, sqrt_root;
    logic [RW-1:0]             sqrt_rad;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign load_we   = s_fire && (s_data.op == rcxh_pkg::OP_LOAD) &&
                       (32'(s_data.plane_slot) < NP);
    assign cfg_ready = 1'b1;

    always_comb begin
        tidx  = (job_reg == J_IN) ? j_reg : pi_reg;
        ent   = table_reg[tidx];
        case (k_reg)
            2'd0:    nk = ent.nx;
            2'd1:    nk = ent.ny;
            default: nk = ent.nz;
        endcase
        ok  = o_reg[k_reg];
        dk  = d_reg[k_reg];
        pk  = p_reg[k_reg];
        bpk = bp_reg[k_reg];

        // floored Q16.16 product from the previous cycle
        fprod   = AW'($signed(prod_reg[PRW-1:16]));
        base    = (job_reg == J_DOT) ? '0 : AW'(ent.off);
        acc_sum = ((k_reg == 2'd0) ? base : acc_reg) + fprod;
        pt_sum  = AW'(ok) + fprod;
        if (pt_sum > MAX32)      pt_sat = 32'sh7FFF_FFFF;
        else if (pt_sum < MIN32) pt_sat = -32'sh8000_0000;
        else                     pt_sat = pt_sum[31:0];

        df    = 33'(bpk) - 33'(ok);
        dm    = (df < 0) ? -df : df;
        far_k = (dm[32:31] != 2'b00);

        case (job_reg)
            J_VAL:   begin mul_a = MW'(nk); mul_b = MW'(ok); end
            J_DOT:   begin mul_a = MW'(nk); mul_b = MW'(dk); end
            J_PT:    begin mul_a = MW'(dk); mul_b = $signed({2'b00, t_reg}); end
            J_IN:    begin mul_a = MW'(nk); mul_b = MW'(pk); end
            default: begin
                mul_a = $signed({2'b00, dm[30:0]});
                mul_b = $signed({2'b00, dm[30:0]});
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        job_next     = job_reg;
        k_next       = k_reg;
        pi_next      = pi_reg;
        j_next       = j_reg;
        acc_next     = acc_reg;
        val_next     = val_reg;
        t_next       = t_reg;
        best_t_next  = best_t_reg;
        found_next   = found_reg;
        sum_next     = sum_reg;
        far_next     = far_reg;
        dist_next    = dist_reg;
        prod_next    = prod_reg;
        p_next       = p_reg;
        bp_next      = bp_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        div_start    = 1'b0;
        div_num      = (val_reg < 0) ? AW'(-val_reg) : AW'(val_reg);
        div_den      = (acc_sum < 0) ? AW'(-acc_sum) : AW'(acc_sum);
        sqrt_start   = 1'b0;
        sqrt_rad     = sum_reg[RW-1:0];
        adv          = 1'b0;

        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_data.op == rcxh_pkg::OP_QUERY) begin
                    pi_next     = '0;
                    k_next      = '0;
                    job_next    = J_VAL;
                    found_next  = 1'b0;
                    best_t_next = rcxh_pkg::SAT31;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next  = mul_a * mul_b;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                state_next = ST_MUL;
                k_next     = k_reg + 2'd1;
                case (job_reg)
                    J_VAL: begin
                        acc_next = acc_sum;
                        if (k_reg == 2'd2) begin
                            val_next = acc_sum;
                            job_next = J_DOT;
                            k_next   = '0;
                        end
                    end
                    J_DOT: begin
                        acc_next = acc_sum;
                        if (k_reg == 2'd2) begin
                            // plane must face the ray from the origin's side
                            if (val_reg == 0 || acc_sum == 0 ||
                                ((val_reg > 0) == (acc_sum > 0))) begin
                                adv = 1'b1;
                            end else begin
                                div_start  = 1'b1;
                                state_next = ST_DIV;
                            end
                        end
                    end
                    J_PT: begin
                        p_next[k_reg] = pt_sat;
                        if (k_reg == 2'd2) begin
                            job_next = J_IN;
                            j_next   = '0;
                            k_next   = '0;
                        end
                    end
                    J_IN: begin
                        acc_next = acc_sum;
                        if (k_reg == 2'd2) begin
                            k_next = '0;
                            if (acc_sum > $signed(AW'(tol_reg))) begin
                                adv = 1'b1;
                            end else if (32'(j_reg) == NP - 1) begin
                                found_next  = 1'b1;
                                best_t_next = t_reg;
                                bp_next     = p_reg;
                                adv         = 1'b1;
                            end else begin
                                j_next = j_reg + PW'(1);
                            end
                        end
                    end
                    default: begin
                        far_next = far_reg | far_k;
                        if (!far_k) sum_next = sum_reg + SMW'(prod_reg[RW-1:0]);
                        if (k_reg == 2'd2) begin
                            if (far_next || sum_next >= FAR_LIMIT) begin
                                dist_next  = rcxh_pkg::SAT31;
                                state_next = ST_OUT;
                            end else begin
                                sqrt_rad   = sum_next[RW-1:0];
                                sqrt_start = 1'b1;
                                state_next = ST_SQRT;
                            end
                        end
                    end
                endcase
            end
            ST_DIV: begin
                if (div_done) begin
                    t_next = div_q;
                    if (found_reg && div_q >= best_t_reg) begin
                        adv = 1'b1;
                    end else begin
                        job_next   = J_PT;
                        k_next     = '0;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_SQRT: begin
                if (sqrt_done) begin
                    dist_next  = sqrt_root;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next.hit       = found_reg;
                    m_data_next.hit_x     = found_reg ? bp_reg[0] : '0;
                    m_data_next.hit_y     = found_reg ? bp_reg[1] : '0;
                    m_data_next.hit_z     = found_reg ? bp_reg[2] : '0;
                    m_data_next.ray_param = best_t_reg;
                    m_data_next.distance  = found_reg ? dist_reg : rcxh_pkg::SAT31;
                    m_valid_next          = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // move on to the next candidate plane, or finish the scan
        if (adv) begin
            k_next = '0;
            if (32'(pi_reg) == NP - 1) begin
                if (found_next) begin
                    job_next   = J_DST;
                    sum_next   = '0;
                    far_next   = 1'b0;
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_OUT;
                end
            end else begin
                pi_next    = pi_reg + PW'(1);
                job_next   = J_VAL;
                state_next = ST_MUL;
            end
        end
    end

    rcxh_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_q)
    );

    rcxh_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sqrt_rad),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            job_reg     <= J_VAL;
            k_reg       <= '0;
            pi_reg      <= '0;
            j_reg       <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            tol_reg     <= rcxh_pkg::TOL_RESET;
            for (int i = 0; i < NP; i++) table_reg[i] <= '0;
        end else begin
            state_reg   <= state_next;
            job_reg     <= job_next;
            k_reg       <= k_next;
            pi_reg      <= pi_next;
            j_reg       <= j_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) tol_reg <= cfg_data;
            if (load_we) begin
                table_reg[PW'(s_data.plane_slot)] <= '{
                    nx:  s_data.normal_x,
                    ny:  s_data.normal_y,
                    nz:  s_data.normal_z,
                    off: s_data.plane_offset
                };
            end
        end
        acc_reg    <= acc_next;
        val_reg    <= val_next;
        t_reg      <= t_next;
        best_t_reg <= best_t_next;
        sum_reg    <= sum_next;
        far_reg    <= far_next;
        dist_reg   <= dist_next;
        prod_reg   <= prod_next;
        p_reg      <= p_next;
        bp_reg     <= bp_next;
        m_data_reg <= m_data_next;
        if (s_fire && s_data.op == rcxh_pkg::OP_QUERY) begin
            o_reg[0] <= s_data.origin_x;
            o_reg[1] <= s_data.origin_y;
            o_reg[2] <= s_data.origin_z;
            d_reg[0] <= s_data.dir_x;
            d_reg[1] <= s_data.dir_y;
            d_reg[2] <= s_data.dir_z;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
